>>> hdl/pcf_pkg.sv
// Shared types, operation codes and CRC-32 fold functions for the PNG chunk framer.
// No dependencies.
package pcf_pkg;

  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // CRC update request from the input stage to the CRC register
  typedef struct packed {
    logic        load;
    logic [1:0]  op;
    logic [31:0] chunk_type;
    logic [7:0]  data_byte;
  } pcf_crc_req_t;

  // Reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_fold_byte(input logic [31:0] c_in,
                                                input logic [7:0]  b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = CRC_POLY ^ (c >> 1);
      else      c = c >> 1;
    end
    return c;
  endfunction

  // Fold the four type bytes, top byte first, from the preset
  function automatic logic [31:0] crc_fold_type(input logic [31:0] w);
    logic [31:0] c;
    c = CRC_ONES;
    for (int i = 3; i >= 0; i--) begin
      c = crc_fold_byte(c, w[8*i +: 8]);
    end
    return c;
  endfunction

endpackage

>>> hdl/pcf_crc.sv
// Running CRC-32 register for the PNG chunk framer.
// Depends on pcf_pkg for the request struct, op codes and fold functions.
module pcf_crc
  import pcf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  pcf_crc_req_t req,
  output logic [31:0]  crc_final
);

  logic [31:0] crc_accum;
  logic [31:0] crc_accum_next;

  always_comb begin
    crc_accum_next = crc_accum;
    if (req.load) begin
      unique case (req.op)
        OP_BEGIN:  crc_accum_next = crc_fold_type(req.chunk_type);
        OP_DATA:   crc_accum_next = crc_fold_byte(crc_accum, req.data_byte);
        OP_FINISH: crc_accum_next = CRC_ONES;
        default:   crc_accum_next = crc_accum;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum <= CRC_ONES;
    end else begin
      crc_accum <= crc_accum_next;
    end
  end

  assign crc_final = crc_accum ^ CRC_ONES;

endmodule

>>> hdl/png_chunk_framer_crc32.sv
// PNG chunk framer: one input word in, 8 (begin), 1 (data) or 4 (finish) output bytes out,
// one byte per cycle while out_stall is low. An input register holds one word while the byte
// serialiser drains and stalls the input until the serialiser frees; the serialiser therefore
// sets the sustained word rate. With both stages empty a word passes through the input register
// and then the serialiser before its first byte is presented. Op code 3 is accepted and dropped.
// No reset sweep; the block is ready the cycle after reset.
// Depends on pcf_pkg and pcf_crc.
module png_chunk_framer_crc32
  import pcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] chunk_type,
  input  logic [30:0] chunk_length,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        run_last
);

  // input register
  logic        a_valid;
  logic [1:0]  a_op;
  logic [31:0] a_type;
  logic [30:0] a_len;
  logic [7:0]  a_data;

  // byte serialiser, top byte goes out first
  logic [63:0] ser_data;
  logic [63:0] ser_data_next;
  logic [3:0]  ser_cnt;
  logic [3:0]  ser_cnt_next;

  logic         ser_free;
  logic         a_move;
  logic         in_take;
  logic         out_take;
  logic [31:0]  crc_final;
  pcf_crc_req_t crc_req;

  assign out_valid = (ser_cnt != 4'd0);
  assign out_byte  = ser_data[63:56];
  assign run_last  = (ser_cnt == 4'd1);
  assign out_take  = out_valid && !out_stall;

  assign ser_free = (ser_cnt == 4'd0) || (ser_cnt == 4'd1 && !out_stall);
  assign a_move   = a_valid && ser_free;
  assign in_stall = a_valid && !ser_free;
  assign in_take  = in_valid && !in_stall;

  assign crc_req.load       = a_move;
  assign crc_req.op         = a_op;
  assign crc_req.chunk_type = a_type;
  assign crc_req.data_byte  = a_data;

  pcf_crc u_crc (
    .clk       (clk),
    .rst       (rst),
    .req       (crc_req),
    .crc_final (crc_final)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take && op != OP_NONE) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_op   <= op;
      a_type <= chunk_type;
      a_len  <= chunk_length;
      a_data <= data_byte;
    end
  end

  always_comb begin
    ser_data_next = ser_data;
    ser_cnt_next  = ser_cnt;
    if (out_take) begin
      ser_data_next = {ser_data[55:0], 8'd0};
      ser_cnt_next  = ser_cnt - 4'd1;
    end
    if (a_move) begin
      unique case (a_op)
        OP_BEGIN: begin
          ser_data_next = {1'b0, a_len, a_type};
          ser_cnt_next  = 4'd8;
        end
        OP_DATA: begin
          ser_data_next = {a_data, 56'd0};
          ser_cnt_next  = 4'd1;
        end
        OP_FINISH: begin
          ser_data_next = {crc_final, 32'd0};
          ser_cnt_next  = 4'd4;
        end
        default: begin
          ser_data_next = ser_data;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_cnt <= 4'd0;
    end else begin
      ser_cnt <= ser_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ser_data <= ser_data_next;
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    ser_cnt <= 4'd8)
    else $error("serialiser count out of range");

  a_begin_load: assert property (@(posedge clk) disable iff (rst)
    a_move && a_op == OP_BEGIN |=> ser_cnt == 4'd8)
    else $error("begin word did not load eight bytes");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> ser_cnt == $past(ser_cnt))
    else $error("serialiser changed while output stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> a_valid && out_valid)
    else $error("input stalled with nothing pending");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for png_chunk_framer_crc32: drives all four op codes and checks the framed
// byte stream against a self-contained CRC-32 chunk predictor. Depends on pcf_pkg and the RTL.
module tb_top;
  import pcf_pkg::*;

  class chunk_scoreboard;
    typedef struct {
      logic [7:0] b;
      logic       last;
    } framed_byte_t;

    bit [31:0]    crc_reg;
    framed_byte_t framed_q[$];
    int           errors;
    int           bytes_seen;

    function new();
      crc_reg    = CRC_ONES;
      errors     = 0;
      bytes_seen = 0;
    endfunction

    // reflected CRC-32, one byte, LSB first
    static function bit [31:0] crc_byte(bit [31:0] c, bit [7:0] b);
      bit [31:0] r;
      r = c ^ {24'd0, b};
      repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
      return r;
    endfunction

    function void push(bit [7:0] b, bit last);
      framed_byte_t e;
      e.b    = b;
      e.last = last;
      framed_q.push_back(e);
    endfunction

    function int pending();
      return framed_q.size();
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    // expected bytes for one accepted input word
    function void note_word(logic [1:0] op, logic [31:0] ty, logic [30:0] len,
                            logic [7:0] d);
      bit [31:0] len_w;
      bit [31:0] fin;
      len_w = {1'b0, len};
      case (op)
        OP_BEGIN: begin
          crc_reg = CRC_ONES;
          for (int i = 3; i >= 0; i--) push(len_w[8*i +: 8], 1'b0);
          for (int i = 3; i >= 0; i--) begin
            push(ty[8*i +: 8], i == 0);
            crc_reg = crc_byte(crc_reg, ty[8*i +: 8]);
          end
        end
        OP_DATA: begin
          push(d, 1'b1);
          crc_reg = crc_byte(crc_reg, d);
        end
        OP_FINISH: begin
          fin = ~crc_reg;
          for (int i = 3; i >= 0; i--) push(fin[8*i +: 8], i == 0);
          crc_reg = CRC_ONES;
        end
        default: ;  // unused code: dropped
      endcase
    endfunction

    function void check_byte(logic [7:0] got_b, logic got_last);
      framed_byte_t e;
      bytes_seen++;
      if (framed_q.size() == 0) begin
        fail($sformatf("unexpected byte %h last %b", got_b, got_last));
        return;
      end
      e = framed_q.pop_front();
      if (got_b !== e.b || got_last !== e.last)
        fail($sformatf("byte %0d: expected %h last %b, got %h last %b",
                       bytes_seen, e.b, e.last, got_b, got_last));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  op;
  logic [31:0] chunk_type;
  logic [30:0] chunk_length;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        run_last;

  chunk_scoreboard sb = new();
  bit calm = 1'b0;
  int n_begin, n_data, n_finish, n_ignored;

  png_chunk_framer_crc32 dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .chunk_type(chunk_type), .chunk_length(chunk_length), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .run_last(run_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 8);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_byte(out_byte, run_last);
  end

  // entered just after a falling edge; leaves just after a falling edge
  task automatic send_word(logic [1:0] o, logic [31:0] ty, logic [30:0] len, logic [7:0] d);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    chunk_type   <= ty;
    chunk_length <= len;
    data_byte    <= d;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(o, ty, len, d);
    case (o)
      OP_BEGIN:  n_begin++;
      OP_DATA:   n_data++;
      OP_FINISH: n_finish++;
      default:   n_ignored++;
    endcase
    @(negedge clk);
  endtask

  task automatic send_data(logic [7:0] d);
    send_word(OP_DATA, $urandom, 31'($urandom), d);
  endtask

  task automatic send_begin(logic [31:0] ty, logic [30:0] len);
    send_word(OP_BEGIN, ty, len, 8'($urandom));
  endtask

  task automatic send_finish();
    send_word(OP_FINISH, $urandom, 31'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] random_type();
    logic [31:0] t;
    if ($urandom_range(0, 99) < 30) return $urandom;
    for (int i = 0; i < 4; i++)
      t[8*i +: 8] = 8'(8'h41 + $urandom_range(0, 25) +
                       ($urandom_range(0, 1) ? 8'h20 : 8'h00));
    return t;
  endfunction

  initial begin
    int nbytes;
    int chunk_no;
    rst          = 1'b1;
    in_valid     = 1'b0;
    op           = OP_NONE;
    chunk_type   = '0;
    chunk_length = '0;
    data_byte    = '0;
    out_stall    = 1'b0;
    n_begin = 0; n_data = 0; n_finish = 0; n_ignored = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // data and finish straight after reset run on the preset CRC
    send_data(8'h00);
    send_data(8'hFF);
    send_finish();
    send_finish();  // back-to-back finish: CRC was re-preset
    send_word(OP_NONE, $urandom, 31'($urandom), 8'($urandom));
    // empty IEND chunk
    send_begin(32'h49454E44, 31'd0);
    send_finish();
    // extremes of type and length
    send_begin(32'hFFFFFFFF, 31'h7FFFFFFF);
    send_data(8'h00);
    send_data(8'hFF);
    send_finish();
    // begin inside an open chunk drops it; unused code mid-chunk is ignored
    send_begin(32'h00000000, 31'd0);
    send_data(8'hA5);
    send_begin(32'h49444154, 31'd2);
    send_data(8'h5A);
    send_word(OP_NONE, $urandom, 31'($urandom), 8'($urandom));
    send_data(8'h80);
    send_finish();

    chunk_no = 0;
    while (n_begin + n_data + n_finish < 110) begin
      calm = (chunk_no >= 6 && chunk_no < 11);
      if ($urandom_range(0, 99) < 15) begin
        // noise: stray words of any code
        repeat ($urandom_range(1, 3))
          send_word(2'($urandom_range(0, 3)), $urandom, 31'($urandom), 8'($urandom));
      end else begin
        nbytes = $urandom_range(0, 12);
        send_begin(random_type(), $urandom_range(0, 1) ? 31'(nbytes) : 31'($urandom));
        repeat (nbytes) send_data(8'($urandom));
        if ($urandom_range(0, 99) < 90) send_finish();
      end
      if (chunk_no == 3) wait_drained();  // sender holds off until the stream is empty
      chunk_no++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (16) @(negedge clk);
    $display("Covered %0d chunk starts, %0d payload words, %0d finishes, %0d ignored words;",
             n_begin, n_data, n_finish, n_ignored);
    $display("%0d output bytes checked, %0d mismatches, %0d bytes still outstanding.",
             sb.bytes_seen, sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timeout waiting for the framed stream to drain");
    $display("Some tests failed");
    $finish;
  end

endmodule
